// ----- sv/repeating_timer_queue_defines.svh -----
// Assertion macros for the repeating timer queue
`ifndef REPEATING_TIMER_QUEUE_DEFINES_SVH
`define REPEATING_TIMER_QUEUE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset
`define RTQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication outside reset
`define RTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- sv/rtq_pkg.sv -----
// ----------------------------------------------------------------------------
// rtq_pkg
// Types and constants shared by the repeating timer queue.
// ----------------------------------------------------------------------------
package rtq_pkg;
  localparam int unsigned TimeW        = 48;
  localparam int unsigned HandleW      = 8;
  localparam int unsigned DelayW       = 24;
  localparam int unsigned CapacityDef  = 16;
  localparam int unsigned MaxResults   = 16;
  localparam logic [DelayW-1:0] MinDelayReset = 24'd100000;
  localparam logic [TimeW-1:0]  TimeMax = '1;

  typedef enum logic [1:0] {
    KIND_ADDED    = 2'd0,
    KIND_EXPIRED  = 2'd1,
    KIND_REJECTED = 2'd2
  } kind_e;

  typedef enum logic {
    ACT_ADD  = 1'b0,
    ACT_TICK = 1'b1
  } action_e;

  // One timer entry carried through the chain
  typedef struct packed {
    logic               vld;
    logic [TimeW-1:0]   expiry;
    logic [TimeW-1:0]   interval;
    logic [HandleW-1:0] handle;
  } entry_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic               ins;   // insert key into sorted chain
    logic               pop;   // shift chain one place toward head
    entry_t             key;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_COUNT,
    ST_POP,
    ST_REINS,
    ST_EMIT
  } state_e;

  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? TimeMax : s[TimeW-1:0];
  endfunction
endpackage

// ----- sv/rtq_intf.sv -----
// ----------------------------------------------------------------------------
// rtq_in_if / rtq_out_if / rtq_cfg_if
// Valid/ready channels of the repeating timer queue.
// ----------------------------------------------------------------------------
interface rtq_in_if import rtq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [HandleW-1:0] timer_handle;
  logic [TimeW-1:0]   expire_time;
  logic [TimeW-1:0]   repeat_interval;
  logic [TimeW-1:0]   now_time;
  modport source (output valid, action, timer_handle, expire_time, repeat_interval,
                  now_time, input ready);
  modport sink (input valid, action, timer_handle, expire_time, repeat_interval,
                now_time, output ready);
endinterface

interface rtq_out_if import rtq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [HandleW-1:0] handle_out;
  logic               rearm;
  logic [TimeW-1:0]   arm_time;
  logic               last;
  modport source (output valid, kind, handle_out, rearm, arm_time, last,
                  input ready);
  modport sink (input valid, kind, handle_out, rearm, arm_time, last,
                output ready);
endinterface

interface rtq_cfg_if import rtq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DelayW-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- sv/rtq_cell.sv -----
// ----------------------------------------------------------------------------
// rtq_cell
// One slot of the sorted chain: keeps, takes the key, or takes a neighbor.
// ----------------------------------------------------------------------------
module rtq_cell import rtq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_cmd_t cmd_i,
  input  entry_t    left_i,     // neighbor toward head
  input  logic      left_gt_i,  // neighbor toward head is free or holds expiry > key
  input  entry_t    right_i,    // neighbor toward tail
  output entry_t    ent_o,
  output logic      gt_o        // this slot is free or its expiry > key
);
  entry_t ent_q, ent_d;
  logic   vld_q;

  assign gt_o  = !vld_q || (ent_q.expiry > cmd_i.key.expiry);
  assign ent_o = '{vld: vld_q, expiry: ent_q.expiry, interval: ent_q.interval,
                   handle: ent_q.handle};

  // Pop: take the tail-side neighbor; insert: first greater slot takes the key, later ones shift toward tail
  always_comb begin
    ent_d = ent_o;
    if (cmd_i.pop) begin
      ent_d = right_i;
    end else if (cmd_i.ins && gt_o) begin
      if (left_gt_i) ent_d = left_i;
      else           ent_d = '{vld: 1'b1, expiry: cmd_i.key.expiry,
                               interval: cmd_i.key.interval, handle: cmd_i.key.handle};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else         vld_q <= ent_d.vld;
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end
endmodule

// ----- sv/rtq_chain.sv -----
// ----------------------------------------------------------------------------
// rtq_chain
// Row of CAPACITY cells holding the timers sorted by expiry.
// ----------------------------------------------------------------------------
module rtq_chain import rtq_pkg::*; #(
  parameter int unsigned Capacity = CapacityDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cell_cmd_t                       cmd_i,
  input  logic [TimeW-1:0]                now_i,
  input  logic [$clog2(Capacity)-1:0]     sel_i,
  output entry_t                          head_o,
  output entry_t                          sel_o,
  output logic [$clog2(Capacity+1)-1:0]   exp_num_o,
  output logic                            full_o
);
  localparam int unsigned NumW = $clog2(Capacity + 1);

  entry_t ent   [Capacity];
  logic   gt    [Capacity];
  logic   lt    [Capacity];

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    entry_t left_w, right_w;
    logic   lgt_w;
    if (i == 0) begin : g_head
      assign left_w = '0;
      assign lgt_w  = 1'b0;
    end else begin : g_mid
      assign left_w = ent[i-1];
      assign lgt_w  = gt[i-1];
    end
    if (i == Capacity - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_nxt
      assign right_w = ent[i+1];
    end
    rtq_cell u_cell (
      .clk_i, .rst_ni, .cmd_i,
      .left_i(left_w), .left_gt_i(lgt_w), .right_i(right_w),
      .ent_o(ent[i]), .gt_o(gt[i])
    );
    // Slot holds a timer whose expiry is before now_i
    assign lt[i] = ent[i].vld && (ent[i].expiry < now_i);
  end

  // Number of due timers; they form a prefix of the sorted chain
  always_comb begin
    logic [NumW-1:0] num;
    num = '0;
    for (int j = 0; j < Capacity; j++) begin
      num = num + NumW'(lt[j]);
    end
    exp_num_o = num;
  end

  assign head_o = ent[0];
  assign sel_o  = ent[sel_i];
  assign full_o = ent[Capacity-1].vld;
endmodule

// ----- sv/repeating_timer_queue.sv -----
// Sequencing: an add result is registered from ST_ADD; a tick passes ST_COUNT, then
//   ST_POP, ST_REINS and ST_EMIT for each expired timer, ST_POP waiting on back-pressure.
// Throughput: one item at a time, taken only in ST_IDLE with no result pending; a tick
//   gives k results for k expired timers (k <= MaxResults), none when nothing expires.
// Reset: asynchronous active low; all slots empty, min_arm_delay = 100000.
// ----------------------------------------------------------------------------
// repeating_timer_queue
// Sorted timer table on a chain of cells, with tick expiry and rearm report.
// ----------------------------------------------------------------------------
`include "repeating_timer_queue_defines.svh"
module repeating_timer_queue import rtq_pkg::*; #(
  parameter int unsigned Capacity = CapacityDef
) (
  input logic clk_i,
  input logic rst_ni,
  rtq_in_if.sink    in_if,
  rtq_out_if.source out_if,
  rtq_cfg_if.sink   cfg_if
);
  localparam int unsigned CntW = $clog2(MaxResults + 1);
  localparam int unsigned NumW = $clog2(Capacity + 1);
  localparam int unsigned IdxW = $clog2(Capacity);

  state_e state_q, state_d;
  logic [DelayW-1:0]  dly_q;
  logic [TimeW-1:0]   now_q;
  entry_t             key_q, key_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               ovld_q, ovld_d;
  logic [1:0]         okind_q, okind_d;
  logic [HandleW-1:0] ohdl_q, ohdl_d;
  logic               ochg_q, ochg_d, olast_q, olast_d;
  logic [TimeW-1:0]   oarm_q, oarm_d;
  cell_cmd_t          cmd;
  entry_t             head, sel;
  logic               full;
  logic [NumW-1:0]    exp_num;
  logic [CntW-1:0]    exp_cnt;
  logic               in_xfer;
  logic [TimeW-1:0]   lo_time, sel_arm;

  rtq_chain #(.Capacity(Capacity)) u_chain (
    .clk_i, .rst_ni, .cmd_i(cmd), .now_i(now_q), .sel_i(IdxW'(cnt_q)),
    .head_o(head), .sel_o(sel), .exp_num_o(exp_num), .full_o(full)
  );

  assign in_if.ready  = (state_q == ST_IDLE) && !ovld_q;
  assign in_xfer      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign lo_time  = sat_add(now_q, {{(TimeW-DelayW){1'b0}}, dly_q});
  // During a tick the earliest pending timer sits behind the not yet popped ones
  assign sel_arm  = (sel.expiry > lo_time) ? sel.expiry : lo_time;
  assign exp_cnt  = (32'(exp_num) > MaxResults) ? CntW'(MaxResults) : CntW'(exp_num);

  // Sequencer
  always_comb begin
    state_d = state_q; key_d = key_q; cnt_d = cnt_q;
    ovld_d = ovld_q && !out_if.ready;
    okind_d = okind_q; ohdl_d = ohdl_q; ochg_d = ochg_q; oarm_d = oarm_q;
    olast_d = olast_q;
    cmd = '0; cmd.key = key_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          key_d = '{vld: 1'b1, expiry: in_if.expire_time,
                    interval: in_if.repeat_interval, handle: in_if.timer_handle};
          cnt_d = '0;
          state_d = (action_e'(in_if.action) == ACT_ADD) ? ST_ADD : ST_COUNT;
        end
      end
      ST_ADD: begin
        ovld_d = 1'b1; ohdl_d = key_q.handle; olast_d = 1'b1;
        if (full) begin
          okind_d = KIND_REJECTED; ochg_d = 1'b0; oarm_d = '0;
        end else begin
          cmd.ins = 1'b1;
          okind_d = KIND_ADDED;
          ochg_d  = !head.vld || (key_q.expiry < head.expiry);
          oarm_d  = ochg_d ? ((key_q.expiry > lo_time) ? key_q.expiry : lo_time) : '0;
        end
        state_d = ST_IDLE;
      end
      ST_COUNT: begin
        // Number of timers this tick expires
        cnt_d = exp_cnt;
        state_d = (exp_cnt == '0) ? ST_IDLE : ST_POP;
      end
      ST_POP: begin
        // Wait for the previous result to leave before making the next
        if (!ovld_q || out_if.ready) begin
          cmd.pop = 1'b1;
          key_d = '{vld: 1'b1, expiry: sat_add(now_q, head.interval),
                    interval: head.interval, handle: head.handle};
          cnt_d = cnt_q - CntW'(1);
          state_d = ST_REINS;
        end
      end
      ST_REINS: begin
        cmd.ins = (key_q.interval != '0);
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        // cnt_q timers are still due ahead of the earliest pending one
        okind_d = KIND_EXPIRED; ohdl_d = key_q.handle;
        ochg_d = sel.vld; oarm_d = sel.vld ? sel_arm : '0;
        olast_d = (cnt_q == '0);
        if (!ovld_q || out_if.ready) begin
          ovld_d = 1'b1;
          state_d = olast_d ? ST_IDLE : ST_POP;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; ovld_q <= 1'b0; dly_q <= MinDelayReset;
      cnt_q <= '0;
    end else begin
      state_q <= state_d; ovld_q <= ovld_d; cnt_q <= cnt_d;
      if (cfg_if.valid && cfg_if.ready) dly_q <= cfg_if.data;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d; okind_q <= okind_d; ohdl_q <= ohdl_d; ochg_q <= ochg_d;
    oarm_q <= oarm_d; olast_q <= olast_d;
    if (in_xfer) now_q <= in_if.now_time;
  end

  assign out_if.valid = ovld_q;
  assign out_if.kind = okind_q;
  assign out_if.handle_out = ohdl_q;
  assign out_if.rearm = ochg_q;
  assign out_if.arm_time = oarm_q;
  assign out_if.last = olast_q;

  `RTQ_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, state_q != ST_IDLE, !in_if.ready)
  `RTQ_ASSERT_IMP(a_rej_quiet, clk_i, rst_ni,
    ovld_q && okind_q == KIND_REJECTED, !ochg_q && oarm_q == '0)
  `RTQ_ASSERT_NEXT(a_add_one, clk_i, rst_ni, state_q == ST_ADD, ovld_q && olast_q)
endmodule

// ----- bench/tb_repeating_timer_queue.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_repeating_timer_queue
// Self-checking bench for the repeating timer queue: directed tests for adds,
// ties, a full table, ticks, repeats and saturation, a back-pressure test, then
// random traffic, all checked against an in-bench sorted-table predictor.
// ----------------------------------------------------------------------------
module tb_repeating_timer_queue;
  import rtq_pkg::*;

  localparam int unsigned Cap = CapacityDef;
  localparam int unsigned CycleLimit = 1000000;

  logic clk_i;
  logic rst_ni;

  rtq_in_if  in_if ();
  rtq_out_if out_if ();
  rtq_cfg_if cfg_if ();

  repeating_timer_queue #(.Capacity(Cap)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source),
    .cfg_if (cfg_if.sink)
  );

  // Expected result of one transfer on the output channel
  typedef struct packed {
    kind_e              kind;
    logic [HandleW-1:0] handle;
    logic               changed;
    logic [TimeW-1:0]   arm;
    logic               last;
  } timer_event_t;

  // Predictor copy of the timer table and the delay register
  logic [DelayW-1:0]  pred_delay;
  int unsigned        pred_count;
  logic [TimeW-1:0]   pred_expiry   [Cap];
  logic [TimeW-1:0]   pred_interval [Cap];
  logic [HandleW-1:0] pred_handle   [Cap];

  timer_event_t pending_events[$];

  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned expired_seen;
  int unsigned rejected_seen;
  bit          hold_off;
  bit          stall_enable;
  longint unsigned cycle_count;

  function automatic logic [TimeW-1:0] sum_sat(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
  endfunction

  function automatic logic [TimeW-1:0] clamp_arm(logic [TimeW-1:0] exp_t,
                                                 logic [TimeW-1:0] now_t);
    logic [TimeW-1:0] lo;
    lo = sum_sat(now_t, {{(TimeW-DelayW){1'b0}}, pred_delay});
    return (exp_t > lo) ? exp_t : lo;
  endfunction

  // Stable insert: after all entries with an equal expiry
  function automatic void table_insert(logic [TimeW-1:0] e, logic [TimeW-1:0] iv,
                                       logic [HandleW-1:0] h);
    int unsigned pos;
    pos = 0;
    if (pred_count >= Cap) return;
    while (pos < pred_count && pred_expiry[pos] <= e) pos++;
    for (int unsigned i = pred_count; i > pos; i--) begin
      pred_expiry[i]   = pred_expiry[i-1];
      pred_interval[i] = pred_interval[i-1];
      pred_handle[i]   = pred_handle[i-1];
    end
    pred_expiry[pos]   = e;
    pred_interval[pos] = iv;
    pred_handle[pos]   = h;
    pred_count++;
  endfunction

  // Works out the results of one accepted item and queues them
  function automatic void predict_timer_events(action_e act, logic [HandleW-1:0] h,
                                               logic [TimeW-1:0] e, logic [TimeW-1:0] iv,
                                               logic [TimeW-1:0] now_t);
    timer_event_t ev;
    logic [TimeW-1:0]   ex_iv [MaxResults];
    logic [HandleW-1:0] ex_h  [MaxResults];
    int unsigned k;
    if (act == ACT_ADD) begin
      ev.handle = h;
      ev.last   = 1'b1;
      if (pred_count >= Cap) begin
        ev.kind = KIND_REJECTED; ev.changed = 1'b0; ev.arm = '0;
      end else begin
        ev.kind    = KIND_ADDED;
        ev.changed = (pred_count == 0) || (e < pred_expiry[0]);
        ev.arm     = ev.changed ? clamp_arm(e, now_t) : '0;
        table_insert(e, iv, h);
      end
      pending_events.push_back(ev);
      return;
    end
    k = 0;
    while (k < pred_count && k < MaxResults && pred_expiry[k] < now_t) begin
      ex_iv[k] = pred_interval[k];
      ex_h[k]  = pred_handle[k];
      k++;
    end
    if (k == 0) return;
    for (int unsigned i = 0; i + k < pred_count; i++) begin
      pred_expiry[i]   = pred_expiry[i+k];
      pred_interval[i] = pred_interval[i+k];
      pred_handle[i]   = pred_handle[i+k];
    end
    pred_count -= k;
    for (int unsigned i = 0; i < k; i++) begin
      if (ex_iv[i] != 0) table_insert(sum_sat(now_t, ex_iv[i]), ex_iv[i], ex_h[i]);
      ev.kind    = KIND_EXPIRED;
      ev.handle  = ex_h[i];
      ev.changed = (pred_count != 0);
      ev.arm     = (pred_count != 0) ? clamp_arm(pred_expiry[0], now_t) : '0;
      ev.last    = (i + 1 == k);
      pending_events.push_back(ev);
    end
  endfunction

  // Clock, reset and cycle limit
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("Timeout after %0d cycles", cycle_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Receiver: random stall pattern, plus a long hold-off on request
  initial begin
    int unsigned phase;
    out_if.ready = 1'b0;
    phase = 0;
    forever begin
      @(negedge clk_i);
      phase++;
      if (hold_off) out_if.ready <= 1'b0;
      else if (!stall_enable) out_if.ready <= 1'b1;
      else if ((phase / 40) % 3 == 2) out_if.ready <= 1'b1;
      else out_if.ready <= ($urandom_range(0, 99) < 65);
    end
  end

  // Output checker
  initial begin
    timer_event_t exp_ev;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        results_seen++;
        if (pending_events.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result: kind %0d handle %0d", out_if.kind,
                     out_if.handle_out);
        end else begin
          exp_ev = pending_events.pop_front();
          if (exp_ev.kind == KIND_EXPIRED) expired_seen++;
          if (exp_ev.kind == KIND_REJECTED) rejected_seen++;
          if (out_if.kind !== exp_ev.kind || out_if.handle_out !== exp_ev.handle ||
              out_if.rearm !== exp_ev.changed ||
              out_if.arm_time !== exp_ev.arm || out_if.last !== exp_ev.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: exp k%0d h%0d c%0d arm %0h l%0d, got k%0d h%0d c%0d arm %0h l%0d",
                       exp_ev.kind, exp_ev.handle, exp_ev.changed, exp_ev.arm, exp_ev.last,
                       out_if.kind, out_if.handle_out, out_if.rearm,
                       out_if.arm_time, out_if.last);
          end
        end
      end
    end
  end

  // Sends one item; predicts at the accepting edge
  task automatic send_item(action_e act, logic [HandleW-1:0] h, logic [TimeW-1:0] e,
                           logic [TimeW-1:0] iv, logic [TimeW-1:0] now_t);
    in_if.valid           <= 1'b1;
    in_if.action          <= act;
    in_if.timer_handle    <= h;
    in_if.expire_time     <= e;
    in_if.repeat_interval <= iv;
    in_if.now_time        <= now_t;
    do @(posedge clk_i); while (!in_if.ready);
    predict_timer_events(act, h, e, iv, now_t);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic idle_line();
    in_if.valid <= 1'b0;
  endtask

  // Bursty sender gap between items
  int unsigned burst_left;
  task automatic maybe_gap();
    if (burst_left == 0) begin
      idle_line();
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
  endtask

  task automatic drain();
    idle_line();
    while (pending_events.size() != 0) @(negedge clk_i);
    repeat (2 * Cap + 10) @(negedge clk_i);
  endtask

  task automatic write_delay(logic [DelayW-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= d;
    do @(posedge clk_i); while (!cfg_if.ready);
    pred_delay = d;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic flush_table();
    send_item(ACT_TICK, '0, '0, '0, {TimeW{1'b1}});
    drain();
    // Repeating timers re-arm at the max time; those never expire, so
    // swap in one-shot behavior by clearing via enough ticks is impossible.
  endtask

  logic [TimeW-1:0] now_base;

  // Directed: extremes, ties, rejects, saturation
  task automatic test_directed();
    write_delay(24'hFFFFFF);
    send_item(ACT_ADD, 8'h00, 48'd0, 48'd0, 48'd0);
    send_item(ACT_ADD, 8'hFF, {TimeW{1'b1}}, 48'd0, {TimeW{1'b1}});
    send_item(ACT_ADD, 8'hA5, 48'd500, 48'd0, 48'd10);
    send_item(ACT_ADD, 8'h5A, 48'd500, 48'd0, 48'd10);
    send_item(ACT_TICK, 8'hFF, {TimeW{1'b1}}, {TimeW{1'b1}}, 48'd0);
    send_item(ACT_TICK, '0, '0, '0, 48'd500);
    send_item(ACT_TICK, '0, '0, '0, 48'd501);
    send_item(ACT_TICK, '0, '0, '0, {TimeW{1'b1}});
    drain();
    write_delay('0);
    for (int i = 0; i < Cap + 2; i++)
      send_item(ACT_ADD, 8'(i), 48'(1000 - i), 48'd0, 48'd100);
    send_item(ACT_TICK, '0, '0, '0, 48'd2000);
    drain();
    send_item(ACT_ADD, 8'h11, 48'd10, 48'h7FFF_FFFF_FFFF, 48'd0);
    send_item(ACT_ADD, 8'h22, 48'd10, {TimeW{1'b1}}, 48'd0);
    send_item(ACT_TICK, '0, '0, '0, 48'h8000_0000_0001);
    send_item(ACT_TICK, '0, '0, '0, {TimeW{1'b1}});
    drain();
  endtask

  // Send a run of adds while the receiver holds off
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++)
        send_item(ACT_ADD, 8'($urandom), 48'($urandom_range(0, 50)), 48'd0, 48'd0);
    join
    send_item(ACT_TICK, '0, '0, '0, 48'd100);
    drain();
  endtask

  // Random: mostly small time windows so timers expire and repeat
  task automatic test_random(int unsigned n);
    logic [TimeW-1:0] e, iv;
    for (int unsigned i = 0; i < n; i++) begin
      maybe_gap();
      if (i % 100 == 50) begin
        drain();
        case ($urandom_range(0, 2))
          0: write_delay('0);
          1: write_delay(24'hFFFFFF);
          default: write_delay(24'($urandom_range(0, 300)));
        endcase
      end
      if ($urandom_range(0, 9) < 6) begin
        e  = ($urandom_range(0, 19) == 0) ? 48'({$urandom, $urandom}) :
             now_base + 48'($urandom_range(0, 400));
        iv = ($urandom_range(0, 2) == 0) ? 48'd0 :
             ($urandom_range(0, 19) == 0) ? 48'({$urandom, $urandom}) :
             48'($urandom_range(1, 300));
        send_item(ACT_ADD, 8'($urandom), e, iv, now_base);
      end else begin
        now_base = now_base + 48'($urandom_range(0, 250));
        send_item(ACT_TICK, 8'($urandom), 48'({$urandom, $urandom}),
                  48'({$urandom, $urandom}), now_base);
      end
    end
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.action = ACT_ADD;
    in_if.timer_handle = '0;
    in_if.expire_time = '0;
    in_if.repeat_interval = '0;
    in_if.now_time = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    pred_delay = MinDelayReset;
    pred_count = 0;
    mismatches = 0; items_sent = 0; results_seen = 0;
    expired_seen = 0; rejected_seen = 0;
    hold_off = 1'b0; stall_enable = 1'b0;
    burst_left = 0;
    now_base = 48'd1000;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    stall_enable = 1'b1;
    test_backpressure();
    test_random(390);

    $display("Sent %0d items, checked %0d results (%0d expiries, %0d rejects)",
             items_sent, results_seen, expired_seen, rejected_seen);
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_events.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
